// ===== src/tdh_pkg.sv =====
// Shared constants and types for the tile dedup hash table.
// No dependencies; used by the top level.
package tdh_pkg;

  localparam int MAX_UNIQUE   = 255;
  localparam int HASH_BUCKETS = 256;
  localparam int ID_W         = 8;
  localparam int TILE_W       = 128;
  localparam logic [ID_W-1:0] EMPTY_ID = 8'hff;
  localparam logic [6:0]      FRAME_MAX = 7'd64;
  localparam logic [6:0]      FRAME_RST = 7'd49;

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_HASH = 8'b0000_0010,
    ST_HEAD = 8'b0000_0100,
    ST_CHK  = 8'b0000_1000,
    ST_WALK = 8'b0001_0000,
    ST_WCMP = 8'b0010_0000,
    ST_INS  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

endpackage

// ===== src/tdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tile_dedup_hash_table.sv =====
// Tile dedup hash table: top level with sequencer, hash adder and chain walk.
// Depends on tdh_pkg and tdh_ram.
//
// Each tile takes one input transaction and yields one output transaction.
// A tile in the base frame passes through accept, four folded-hash adder
// passes, head lookup, check, store and result; a same-position hit goes from
// the check straight to the result. Any other tile alternates between the walk
// and compare states for each chain entry visited, then stores on a miss, and
// gives its result. The shared 64-bit hash adder and the single read port of
// the tile store serialise these steps. On top of that, a tile waits in its
// result state while the previous result is still held on the output. s_tready
// is high only between tiles. Chain heads reset to empty through per-bucket
// valid bits, so no clearing pass is needed after reset or sheet_start.
module tile_dedup_hash_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,      // frame_size
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,        // tile_low [63:0], tile_high [127:64]
  input  logic         s_tuser,        // sheet_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,        // tile_id [7:0], unique_count [15:8]
  output logic [1:0]   m_tuser         // is_new [0], status [1]
);
  import tdh_pkg::*;

  state_t state;
  logic [6:0]   frame_size;
  logic [6:0]   fs;
  logic [63:0]  lo, hi, r;
  logic [1:0]   step;
  id_t          count, cur, best, head_eff;
  logic [5:0]   pos;
  logic         base, full_err;
  logic [HASH_BUCKETS-1:0] head_vld;
  logic [63:0]  add_a, add_b;
  id_t          hash;
  id_t          res_id;
  logic         res_new;

  logic         st_we;
  id_t          st_raddr;
  logic [TILE_W-1:0] st_rdata;
  id_t          ln_rdata, hd_rdata;
  logic         hd_we;
  logic         match;
  logic [6:0]   fs_in;
  logic [6:0]   pos_next;

  assign hash     = r[7:0];
  assign s_tready = (state == ST_IDLE);
  assign match    = (st_rdata == {hi, lo});
  assign fs_in    = (cfg_wdata == 7'd0) ? 7'd1 :
                    (cfg_wdata > FRAME_MAX) ? FRAME_MAX : cfg_wdata;
  assign pos_next = {1'b0, pos} + 7'd1;

  // shared adder: first pass sums the planes, later passes fold
  always_comb begin
    add_a = r;
    add_b = r >> 8;
    unique case (step)
      2'd0: begin add_a = lo; add_b = hi; end
      2'd1: add_b = r >> 32;
      2'd2: add_b = r >> 16;
      2'd3: add_b = r >> 8;
    endcase
  end

  assign st_we = (state == ST_INS) && (count != EMPTY_ID);
  assign hd_we = st_we;
  assign st_raddr = (state == ST_HEAD) ? {2'b00, pos} : cur;

  tdh_ram #(.WIDTH(TILE_W), .DEPTH(MAX_UNIQUE)) u_store (
    .clk(clk), .we(st_we), .waddr(count), .wdata({hi, lo}),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  tdh_ram #(.WIDTH(ID_W), .DEPTH(MAX_UNIQUE)) u_links (
    .clk(clk), .we(st_we), .waddr(count), .wdata(head_eff),
    .raddr(cur), .rdata(ln_rdata)
  );

  tdh_ram #(.WIDTH(ID_W), .DEPTH(HASH_BUCKETS)) u_heads (
    .clk(clk), .we(hd_we), .waddr(hash), .wdata(count),
    .raddr(hash), .rdata(hd_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      frame_size <= FRAME_RST;
      count      <= '0;
      pos        <= '0;
      base       <= 1'b1;
      full_err   <= 1'b0;
      head_vld   <= '0;
      m_tvalid   <= 1'b0;
      step       <= '0;
    end else begin
      if (cfg_we) begin
        frame_size <= fs_in;
      end
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            lo    <= s_tdata[63:0];
            hi    <= s_tdata[127:64];
            fs    <= frame_size;
            step  <= 2'd0;
            best  <= EMPTY_ID;
            state <= ST_HASH;
            if (s_tuser) begin
              head_vld <= '0;
              count    <= '0;
              pos      <= '0;
              base     <= 1'b1;
              full_err <= 1'b0;
            end
          end
        end
        ST_HASH: begin
          r    <= add_a + add_b;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: state <= ST_CHK;
        ST_CHK: begin
          head_eff <= head_vld[hash] ? hd_rdata : EMPTY_ID;
          cur      <= head_vld[hash] ? hd_rdata : EMPTY_ID;
          if (base) begin
            state <= ST_INS;
          end else if (({2'b00, pos} < count) && match) begin
            res_id  <= {2'b00, pos};
            res_new <= 1'b0;
            state   <= ST_FIN;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cur >= count) begin
            if (best != EMPTY_ID) begin
              res_id  <= best;
              res_new <= 1'b0;
              state   <= ST_FIN;
            end else begin
              state <= ST_INS;
            end
          end else begin
            state <= ST_WCMP;
          end
        end
        ST_WCMP: begin
          if (match && (cur < best)) begin
            best <= cur;
          end
          cur   <= ln_rdata;
          state <= ST_WALK;
        end
        ST_INS: begin
          if (count != EMPTY_ID) begin
            head_vld[hash] <= 1'b1;
            res_id         <= count;
            res_new        <= 1'b1;
            count          <= count + 8'd1;
          end else begin
            full_err <= 1'b1;
            res_id   <= '0;
            res_new  <= 1'b0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          // result registers stay put until the previous transaction is taken
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {count, res_id};
            m_tuser  <= {full_err, res_new};
            if (pos_next >= fs) begin
              pos  <= '0;
              base <= 1'b0;
            end else begin
              pos <= pos_next[5:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a newly stored tile is always the last one counted
  a_new_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:8] == m_tdata[7:0] + 8'd1)
    else $error("new tile id does not match count");

  // a matched tile refers to an already stored entry
  a_hit_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[7:0] < m_tdata[15:8])
    else $error("matched id beyond stored count");

  // the store never grows past its depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS && count == EMPTY_ID |=> count == EMPTY_ID && full_err)
    else $error("insert into full table");
`endif

endmodule
